// File: rtl/pwm_pattern_sequencer_assert.svh
// Assertion macros shared by the PWM pattern sequencer RTL.
`ifndef PWM_PATTERN_SEQUENCER_ASSERT_SVH
`define PWM_PATTERN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define PPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types, constants and the fixed pattern table of the PWM pattern sequencer.
// ----------------------------------------------------------------------------
package pps_pkg;

	// Widths of the table fields, independent of the counter parameters.
	localparam int unsigned LEN_W = 14;
	localparam int unsigned LIM_W = 11;

	// Pattern numbering.
	localparam logic [3:0] PAT_NONE    = 4'd0;
	localparam logic [3:0] PAT_FIRST   = 4'd1;
	localparam logic [3:0] PAT_LAST    = 4'd10;

	// Segment codes.
	localparam logic [1:0] SEG_0 = 2'd0;
	localparam logic [1:0] SEG_1 = 2'd1;
	localparam logic [1:0] SEG_2 = 2'd2;

	// One table entry for a pattern and segment.
	typedef struct packed {
		logic             hit;      // entry exists, shadow lengths load
		logic             counted;  // periods are tallied in this segment
		logic             wrap;     // tally limit returns to segment 0
		logic [LEN_W-1:0] period;
		logic [LEN_W-1:0] on_len;
		logic [LIM_W-1:0] limit;
	} seg_entry_t;

	function automatic seg_entry_t mk(input logic counted, input logic wrap,
		input int unsigned per, input int unsigned on_l, input int unsigned lim);
		seg_entry_t e;
		e.hit     = 1'b1;
		e.counted = counted;
		e.wrap    = wrap;
		e.period  = LEN_W'(per);
		e.on_len  = LEN_W'(on_l);
		e.limit   = LIM_W'(lim);
		return e;
	endfunction

	// Pattern table lookup; patterns without an entry return hit = 0.
	function automatic seg_entry_t seg_entry(input logic [3:0] pat, input logic [1:0] seg);
		seg_entry_t e;
		e = '0;
		case (pat)
			4'd1: e = mk(1'b0, 1'b0, 94, 42, 0);
			4'd2: e = mk(1'b0, 1'b0, 94, 64, 0);
			4'd3: e = mk(1'b0, 1'b0, 100, 100, 0);
			4'd4: e = mk(1'b0, 1'b0, 3478, 2817, 0);
			4'd5: begin
				if (seg == SEG_0) e = mk(1'b1, 1'b0, 1974, 1026, 16);
				else if (seg == SEG_1) e = mk(1'b1, 1'b1, 94, 51, 1600);
			end
			4'd6: begin
				if (seg == SEG_0) e = mk(1'b1, 1'b0, 1599, 847, 20);
				else if (seg == SEG_1) e = mk(1'b1, 1'b0, 9588, 4794, 6);
				else if (seg == SEG_2) e = mk(1'b1, 1'b1, 7616, 2818, 5);
			end
			4'd7: begin
				if (seg == SEG_0) e = mk(1'b1, 1'b0, 1128, 564, 5);
				else if (seg == SEG_1) e = mk(1'b1, 1'b0, 3198, 1119, 10);
				else if (seg == SEG_2) e = mk(1'b1, 1'b1, 6293, 5160, 10);
			end
			4'd8: e = mk(1'b0, 1'b0, 8368, 5607, 0);
			4'd9: e = mk(1'b0, 1'b0, 2913, 1398, 0);
			4'd10: begin
				if (seg == SEG_0) e = mk(1'b1, 1'b0, 1973, 943, 10);
				else if (seg == SEG_1) e = mk(1'b1, 1'b0, 9311, 4656, 5);
				else if (seg == SEG_2) e = mk(1'b1, 1'b1, 5640, 2820, 10);
			end
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

// File: rtl/pwm_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// pwm_pattern_sequencer
// PWM generator whose period and on-length follow a fixed pattern table.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on the in channel (requested_pattern, kick) is one 100 us
// tick. Raise kick on the first tick to start the block; afterwards a pattern
// step runs on the tick after every period end, adopting a changed request.
// Each input beat yields exactly one output beat (drive, period_end,
// active_pattern, segment) describing the state after that tick.
// The output beat is valid in the cycle after the input beat is taken.
// Throughput: one tick per cycle unless the receiver stalls; the whole tick update is
// a single pass of counter increments, compares and one table lookup into the state registers.
// The state registers double as the output register, so a new tick is taken
// in the same cycle that the previous output beat is taken.
// When the receiver stalls, the output beat holds and in_ready stays low
// until out_ready returns.
// Reset (arst_n low) clears all state: the output is off, no pattern is
// active and no output beat is pending.
// ----------------------------------------------------------------------------
`include "pwm_pattern_sequencer_assert.svh"

module pwm_pattern_sequencer
	import pps_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 14,
	parameter int unsigned TALLY_WIDTH = 11
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] requested_pattern,
	input  logic       kick,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       drive,
	output logic       period_end,
	output logic [3:0] active_pattern,
	output logic [1:0] segment
);

	// State registers.
	logic                   run_q, pend_q, drive_q, ended_q, ovalid_q;
	logic [COUNT_WIDTH-1:0] tick_q, plen_q, on_q, nplen_q, non_q;
	logic [TALLY_WIDTH-1:0] tally_q;
	logic [3:0]             pat_q;
	logic [1:0]             seg_q;

	// Next-state values.
	logic                   run_n, pend_n, drive_n, ended_n;
	logic [COUNT_WIDTH-1:0] tick_n, plen_n, on_n, nplen_n, non_n;
	logic [TALLY_WIDTH-1:0] tally_n;
	logic [3:0]             pat_n;
	logic [1:0]             seg_n;

	logic accept;

	// The output slot frees when its beat is taken.
	assign in_ready = !ovalid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Pattern step followed by the PWM counter for one tick.
	always_comb begin
		logic                   step, change;
		logic [3:0]             pat_a;
		logic [1:0]             seg_a;
		logic [TALLY_WIDTH-1:0] tally_a, tally_inc;
		logic [COUNT_WIDTH-1:0] tick_a, plen_a, tick_inc;
		seg_entry_t             ent;

		step   = kick || pend_q;
		change = step && (requested_pattern != pat_q);

		pat_a   = change ? requested_pattern : pat_q;
		seg_a   = change ? SEG_0 : seg_q;
		tally_a = change ? '0 : tally_q;
		tick_a  = change ? '0 : tick_q;
		plen_a  = change ? COUNT_WIDTH'(1) : plen_q;

		ent = seg_entry(pat_a, seg_a);

		pat_n     = pat_q;
		seg_n     = seg_a;
		tally_n   = tally_a;
		nplen_n   = nplen_q;
		non_n     = non_q;
		pend_n    = pend_q;
		run_n     = run_q;
		tally_inc = tally_a + TALLY_WIDTH'(1);

		if (step) begin
			pend_n = 1'b0;
			run_n  = 1'b1;
			// A request outside the table falls back to the first pattern.
			if (pat_a == PAT_NONE || pat_a > PAT_LAST) begin
				pat_n = PAT_FIRST;
			end else begin
				pat_n = pat_a;
			end
			if (ent.hit) begin
				nplen_n = COUNT_WIDTH'(ent.period);
				non_n   = COUNT_WIDTH'(ent.on_len);
			end
			// Multi-segment patterns tally periods and move on at the limit.
			if (ent.counted) begin
				if (tally_inc == TALLY_WIDTH'(ent.limit)) begin
					tally_n = '0;
					seg_n   = ent.wrap ? SEG_0 : seg_a + 2'd1;
				end else begin
					tally_n = tally_inc;
				end
			end
		end

		// PWM counter: period end reloads the lengths, on-length turns off.
		tick_n   = tick_a;
		plen_n   = plen_a;
		on_n     = on_q;
		drive_n  = drive_q;
		ended_n  = 1'b0;
		tick_inc = tick_a + COUNT_WIDTH'(1);
		if (run_n) begin
			if (tick_inc == plen_a) begin
				tick_n  = '0;
				drive_n = (on_q != '0);
				plen_n  = nplen_n;
				on_n    = non_n;
				pend_n  = 1'b1;
				ended_n = 1'b1;
			end else begin
				tick_n = tick_inc;
				if (tick_inc == on_q) begin
					drive_n = 1'b0;
				end
			end
		end
	end

	// State update on each accepted input beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			pend_q   <= 1'b0;
			drive_q  <= 1'b0;
			ended_q  <= 1'b0;
			ovalid_q <= 1'b0;
			tick_q   <= '0;
			plen_q   <= '0;
			on_q     <= '0;
			nplen_q  <= '0;
			non_q    <= '0;
			tally_q  <= '0;
			pat_q    <= PAT_NONE;
			seg_q    <= SEG_0;
		end else begin
			if (accept) begin
				run_q   <= run_n;
				pend_q  <= pend_n;
				drive_q <= drive_n;
				ended_q <= ended_n;
				tick_q  <= tick_n;
				plen_q  <= plen_n;
				on_q    <= on_n;
				nplen_q <= nplen_n;
				non_q   <= non_n;
				tally_q <= tally_n;
				pat_q   <= pat_n;
				seg_q   <= seg_n;
			end
			if (accept) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// The state registers are the output beat.
	assign out_valid      = ovalid_q;
	assign drive          = drive_q;
	assign period_end     = ended_q;
	assign active_pattern = pat_q;
	assign segment        = seg_q;

	// Checks on the sequencing logic.
	`PPS_ASSERT_NEXT(a_accept_gives_beat, clk, arst_n, accept, out_valid,
		"accepted tick produced no output beat")
	`PPS_ASSERT_NOW(a_pattern_in_table, clk, arst_n, out_valid, active_pattern <= PAT_LAST,
		"active pattern outside the table")
	`PPS_ASSERT_NOW(a_segment_range, clk, arst_n, out_valid, segment != 2'd3,
		"segment index out of range")
	`PPS_ASSERT_NEXT(a_end_sets_pending, clk, arst_n, accept && ended_n, pend_q && period_end,
		"period end did not schedule a pattern step")
	`PPS_ASSERT_NEXT(a_running_holds, clk, arst_n, run_q, run_q,
		"running dropped after start")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PWM pattern sequencer. Each input beat is one
// tick; a cycle-true predictor of the pattern table and PWM counter computes
// the output beat for every accepted tick, and each output beat is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import pps_pkg::*;

	localparam int unsigned CNT_W = 14;
	localparam int unsigned TAL_W = 11;
	localparam int unsigned DIRECTED_TICKS = 25;
	localparam int unsigned RANDOM_TICKS = 1725;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic [3:0] req;
		logic       kick;
	} tick_item_t;

	typedef struct packed {
		logic       drive;
		logic       period_end;
		logic [3:0] pattern;
		logic [1:0] seg;
	} tick_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [3:0] requested_pattern = 4'd0;
	logic       kick = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       drive;
	logic       period_end;
	logic [3:0] active_pattern;
	logic [1:0] segment;

	pwm_pattern_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.requested_pattern(requested_pattern),
		.kick(kick),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive(drive),
		.period_end(period_end),
		.active_pattern(active_pattern),
		.segment(segment)
	);

	// Clock with an 8 ns period.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Ticks waiting to be sent and output beats still expected.
	tick_item_t   tick_queue[$];
	tick_result_t expected_outputs[$];
	int unsigned  ticks_queued = 0;
	int unsigned  ticks_taken = 0;
	int unsigned  fault_count = 0;
	bit           in_taken = 1'b0;
	bit           out_taken = 1'b0;

	// Predicted sequencer state, all starting at the reset values.
	bit             sq_running = 1'b0;
	bit             sq_pending = 1'b0;
	logic [CNT_W-1:0] sq_tick_cnt = '0;
	logic [CNT_W-1:0] sq_per_len = '0;
	logic [CNT_W-1:0] sq_on_len = '0;
	logic [CNT_W-1:0] sq_next_per = '0;
	logic [CNT_W-1:0] sq_next_on = '0;
	logic [3:0]       sq_pattern = PAT_NONE;
	logic [1:0]       sq_seg = SEG_0;
	logic [TAL_W-1:0] sq_tally = '0;
	bit               sq_level = 1'b0;

	task automatic load_shadow(input int unsigned per, input int unsigned on_l);
		sq_next_per = CNT_W'(per);
		sq_next_on = CNT_W'(on_l);
	endtask

	// One period spent in the current segment; at the limit the segment moves
	// on, or returns to the first one for the last segment.
	task automatic tally_period(input int unsigned limit, input bit back_to_first);
		sq_tally = sq_tally + 1'b1;
		if (sq_tally == limit) begin
			sq_tally = '0;
			if (back_to_first)
				sq_seg = SEG_0;
			else
				sq_seg = sq_seg + 1'b1;
		end
	endtask

	task automatic step_three_segments(
		input int unsigned p0, input int unsigned d0, input int unsigned n0,
		input int unsigned p1, input int unsigned d1, input int unsigned n1,
		input int unsigned p2, input int unsigned d2, input int unsigned n2);
		if (sq_seg == SEG_0) begin
			load_shadow(p0, d0);
			tally_period(n0, 1'b0);
		end else if (sq_seg == SEG_1) begin
			load_shadow(p1, d1);
			tally_period(n1, 1'b0);
		end else if (sq_seg == SEG_2) begin
			load_shadow(p2, d2);
			tally_period(n2, 1'b1);
		end
	endtask

	// Pattern step: adopt a changed request, then pick the next lengths.
	task automatic run_pattern_step(input logic [3:0] req);
		if (req != sq_pattern) begin
			sq_pattern = req;
			sq_seg = SEG_0;
			sq_tally = '0;
			sq_tick_cnt = '0;
			sq_per_len = CNT_W'(1);
		end
		sq_pending = 1'b0;
		sq_running = 1'b0;
		case (sq_pattern)
			4'd1: load_shadow(94, 42);
			4'd2: load_shadow(94, 64);
			4'd3: load_shadow(100, 100);
			4'd4: load_shadow(3478, 2817);
			4'd5: begin
				if (sq_seg == SEG_0) begin
					load_shadow(1974, 1026);
					tally_period(16, 1'b0);
				end else if (sq_seg == SEG_1) begin
					load_shadow(94, 51);
					tally_period(1600, 1'b1);
				end
			end
			4'd6: step_three_segments(1599, 847, 20, 9588, 4794, 6, 7616, 2818, 5);
			4'd7: step_three_segments(1128, 564, 5, 3198, 1119, 10, 6293, 5160, 10);
			4'd8: load_shadow(8368, 5607);
			4'd9: load_shadow(2913, 1398);
			4'd10: step_three_segments(1973, 943, 10, 9311, 4656, 5, 5640, 2820, 10);
			default: sq_pattern = PAT_FIRST;
		endcase
		if (sq_pattern >= PAT_FIRST && sq_pattern <= PAT_LAST)
			sq_running = 1'b1;
	endtask

	// Advance the predicted state by one tick and return the output beat.
	task automatic predict_tick(input tick_item_t t, output tick_result_t r);
		bit ended;
		ended = 1'b0;
		if (t.kick || sq_pending)
			run_pattern_step(t.req);
		if (sq_running) begin
			sq_tick_cnt = sq_tick_cnt + 1'b1;
			if (sq_tick_cnt == sq_per_len) begin
				sq_tick_cnt = '0;
				sq_level = (sq_on_len != '0);
				sq_per_len = sq_next_per;
				sq_on_len = sq_next_on;
				sq_pending = 1'b1;
				ended = 1'b1;
			end else if (sq_tick_cnt == sq_on_len) begin
				sq_level = 1'b0;
			end
		end
		r.drive = sq_level;
		r.period_end = ended;
		r.pattern = sq_pattern;
		r.seg = sq_seg;
	endtask

	task automatic push_tick(input logic [3:0] req, input logic kk);
		tick_item_t t;
		t.req = req;
		t.kick = kk;
		tick_queue.push_back(t);
		ticks_queued++;
	endtask

	// Random runs: half of them a held pattern with kicks that walk the segments,
	// most of the rest short-period runs that see whole periods, and a little noise.
	task automatic queue_random_runs(input int unsigned amount);
		int unsigned made;
		int unsigned len;
		int unsigned kick_odds;
		int unsigned mode;
		logic [3:0]  pat;
		made = 0;
		while (made < amount) begin
			mode = $urandom_range(0, 19);
			pat = 4'($urandom_range(4, 10));
			len = $urandom_range(20, 90);
			kick_odds = $urandom_range(2, 4);
			if (mode < 7) begin
				pat = 4'($urandom_range(1, 3));
				len = $urandom_range(60, 250);
				kick_odds = 30;
			end else if (mode >= 17) begin
				len = $urandom_range(1, 8);
			end
			for (int i = 0; i < len; i++) begin
				if (mode >= 17)
					push_tick(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
				else
					push_tick(pat, $urandom_range(0, kick_odds - 1) == 0);
			end
			made += len;
		end
	endtask

	// Input driver: a beat is offered after a random gap and held until taken.
	int unsigned send_wait = 0;
	bit          tx_calm = 1'b0;

	always @(negedge clk) begin : tick_driver
		bit         present;
		tick_item_t cur;
		present = in_valid && !in_taken;
		if (arst_n && !present) begin
			if (send_wait > 0) begin
				send_wait--;
			end else if (tick_queue.size() > 0) begin
				cur = tick_queue.pop_front();
				requested_pattern <= cur.req;
				kick <= cur.kick;
				present = 1'b1;
				if ($urandom_range(0, 39) == 0)
					tx_calm = !tx_calm;
				send_wait = tx_calm ? 0 : $urandom_range(0, 19);
			end
		end
		in_valid <= present;
	end

	// Output receiver: stalls for a random count after every beat it takes.
	int unsigned rx_hold = 0;
	bit          rx_calm = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				if ($urandom_range(0, 39) == 0)
					rx_calm = !rx_calm;
				rx_hold = rx_calm ? 0 : $urandom_range(0, 19);
			end
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: check output beats, then predict for the accepted tick.
	always @(posedge clk) begin : monitor
		tick_result_t got;
		tick_result_t want;
		tick_item_t   t;
		in_taken = arst_n && in_valid && in_ready;
		out_taken = arst_n && out_valid && out_ready;
		if (out_taken) begin
			got.drive = drive;
			got.period_end = period_end;
			got.pattern = active_pattern;
			got.seg = segment;
			if (expected_outputs.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("%0t: output beat with nothing expected: %p", $realtime, got);
			end else begin
				want = expected_outputs.pop_front();
				if (got.drive !== want.drive || got.period_end !== want.period_end ||
					got.pattern !== want.pattern || got.seg !== want.seg) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("%0t: mismatch expected %p actual %p",
							$realtime, want, got);
				end
			end
		end
		if (in_taken) begin
			t.req = requested_pattern;
			t.kick = kick;
			predict_tick(t, want);
			expected_outputs.push_back(want);
			ticks_taken++;
		end
	end

	// Wait until every queued tick is taken and every output beat has come.
	task automatic wait_drained();
		while (ticks_taken != ticks_queued || expected_outputs.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed ticks: idle before the start, an out-of-range start that
		// leaves a zero period, every pattern, out-of-range requests and a
		// kick burst that walks the segments of one pattern.
		push_tick(4'd10, 1'b0);
		push_tick(4'd15, 1'b1);
		push_tick(4'd1, 1'b0);
		push_tick(4'd1, 1'b0);
		push_tick(4'd3, 1'b1);
		push_tick(4'd3, 1'b0);
		push_tick(4'd1, 1'b1);
		push_tick(4'd2, 1'b1);
		push_tick(4'd4, 1'b1);
		push_tick(4'd5, 1'b1);
		push_tick(4'd6, 1'b1);
		push_tick(4'd8, 1'b1);
		push_tick(4'd9, 1'b1);
		push_tick(4'd10, 1'b1);
		push_tick(4'd0, 1'b1);
		push_tick(4'd0, 1'b0);
		push_tick(4'd11, 1'b1);
		for (int i = 0; i < DIRECTED_TICKS - 19; i++)
			push_tick(4'd7, 1'b1);
		push_tick(4'd7, 1'b0);
		push_tick(4'd12, 1'b0);

		// Hold off the sender until the block has delivered everything.
		wait_drained();
		queue_random_runs(RANDOM_TICKS / 2);
		wait_drained();
		queue_random_runs(RANDOM_TICKS / 2);
		wait_drained();
		repeat (8) @(negedge clk);

		if (fault_count == 0)
			$display("[pwm_pattern_sequencer] OK");
		else
			$display("[pwm_pattern_sequencer] ERROR");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#5ms;
		$display("[pwm_pattern_sequencer] ERROR");
		$finish;
	end

endmodule
